@@ hdl/tcs_pkg.sv @@
// shared constants, types and slot arithmetic for the text console scrollback
`default_nettype none
package tcs_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int HISTORY_LINES = 256;

  localparam int CELLS = HISTORY_LINES * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(HISTORY_LINES);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_SPACE     = 8'd32;
  localparam logic [7:0]  COLOR_RESET  = 8'd7;
  localparam logic [31:0] LINE_MAX     = 32'hFFFF_FFFF;

  typedef logic [SW-1:0] slot_t;
  typedef logic [CW-1:0] col_t;
  typedef logic [15:0]   cell_t;

  typedef enum logic [2:0] {
    OP_PRINT     = 3'd0,
    OP_LINE_UP   = 3'd1,
    OP_LINE_DOWN = 3'd2,
    OP_PAGE_UP   = 3'd3,
    OP_PAGE_DOWN = 3'd4,
    OP_BOTTOM    = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  // one access to the cell memory
  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    cell_t         wdata;
  } ram_req_t;

  // ring slot plus an offset below the ring size
  function automatic slot_t slot_add(input slot_t a, input logic [SW:0] b);
    logic [SW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (SW+2)'(HISTORY_LINES)) s = s - (SW+2)'(HISTORY_LINES);
    return slot_t'(s);
  endfunction

  // ring slot minus an offset below the ring size
  function automatic slot_t slot_sub(input slot_t a, input logic [SW:0] b);
    logic [SW+1:0] s;
    if ({1'b0, a} >= b) s = {2'b00, a} - {1'b0, b};
    else s = {2'b00, a} + (SW+2)'(HISTORY_LINES) - {1'b0, b};
    return slot_t'(s);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input slot_t s, input col_t c);
    return AW'(s) * AW'(COLUMNS) + AW'(c);
  endfunction

endpackage
`default_nettype wire

@@ hdl/tcs_cell_ram.sv @@
// single-port cell memory of the history ring, registered read
`default_nettype none
module tcs_cell_ram
  import tcs_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output cell_t         rdata
);

  cell_t mem [CELLS];

  // write or registered read
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr] <= req.wdata;
    if (req.re) rdata <= mem[req.addr];
  end

endmodule
`default_nettype wire

@@ hdl/text_console_scrollback.sv @@
// text console with scrollback: sequencer, cursor and view state around the cell memory
// sequence: print, scroll and read run S_EXEC, then S_WALK, S_RDWAIT or S_SNAP as needed, then S_RESP and out_valid
// a line advance or clear adds a pass over all COLUMNS cells in S_WALK, one cell write a cycle on the memory port
// throughput: one transaction at a time, busy stays high until its result is issued
// reset: synchronous, active low; afterwards a pass in S_WALK blanks row 0, busy high
// the receiver cannot stall: each result is shown for one cycle only
`default_nettype none
module text_console_scrollback
  import tcs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_screen_row,
  input  wire logic [6:0]  in_screen_col,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  output logic             out_valid,
  output logic [10:0]      out_cursor_pos,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_color,
  output logic             out_view_at_bottom
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_WALK   = 6'b000100,
    S_RDWAIT = 6'b001000,
    S_SNAP   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [4:0]  row_r, row_nxt;
  logic [6:0]  scol_r, scol_nxt;
  logic [7:0]  color_r, color_nxt;
  logic [7:0]  fill_r, fill_nxt;
  logic [31:0] ln_r, ln_nxt;
  slot_t       lslot_r, lslot_nxt;
  col_t        cpos_r, cpos_nxt;
  logic [31:0] view_r, view_nxt;
  slot_t       vslot_r, vslot_nxt;
  slot_t       wslot_r, wslot_nxt;
  col_t        wcol_r, wcol_nxt;
  logic        wresp_r, wresp_nxt;
  logic        hit_r, hit_nxt;
  logic        ov_r, ov_nxt;
  logic [10:0] opos_r, opos_nxt;
  logic [7:0]  och_r, och_nxt;
  logic [7:0]  oco_r, oco_nxt;
  logic        obot_r, obot_nxt;

  ram_req_t ram_req;
  cell_t    ram_rdata;

  logic [31:0] lo, hi, diff;
  slot_t       lo_slot, hi_slot, bslot, nslot;
  col_t        bcol;
  logic [32:0] rline;
  logic [RW-1:0] crow;
  logic [31:0] pos_w;

  tcs_cell_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // oldest and latest view tops with their ring slots
  always_comb begin
    if (ln_r >= 32'(HISTORY_LINES)) begin
      lo      = ln_r - 32'(HISTORY_LINES - 1);
      lo_slot = slot_add(lslot_r, (SW+1)'(1));
    end else begin
      lo      = '0;
      lo_slot = '0;
    end
    if (ln_r >= 32'(ROWS)) begin
      hi      = ln_r - 32'(ROWS - 1);
      hi_slot = slot_sub(lslot_r, (SW+1)'(ROWS - 1));
    end else begin
      hi      = '0;
      hi_slot = '0;
    end
  end

  // backspace target and line advance slot
  always_comb begin
    if (cpos_r == '0) begin
      bcol  = CW'(COLUMNS - 1);
      bslot = slot_sub(lslot_r, (SW+1)'(1));
    end else begin
      bcol  = cpos_r - CW'(1);
      bslot = lslot_r;
    end
    nslot = (ln_r != LINE_MAX) ? slot_add(lslot_r, (SW+1)'(1)) : lslot_r;
    rline = {1'b0, view_r} + 33'(row_r);
  end

  // cursor row within the view
  always_comb begin
    diff = ln_r - view_r;
    crow = '0;
    if (ln_r >= view_r) begin
      if (diff >= 32'(ROWS)) crow = RW'(ROWS - 1);
      else crow = RW'(diff);
    end
    pos_w = 32'(crow) * 32'(COLUMNS) + 32'(cpos_r);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ch_nxt    = ch_r;
    row_nxt   = row_r;
    scol_nxt  = scol_r;
    color_nxt = cfg_we ? cfg_wdata : color_r;
    fill_nxt  = fill_r;
    ln_nxt    = ln_r;
    lslot_nxt = lslot_r;
    cpos_nxt  = cpos_r;
    view_nxt  = view_r;
    vslot_nxt = vslot_r;
    wslot_nxt = wslot_r;
    wcol_nxt  = wcol_r;
    wresp_nxt = wresp_r;
    hit_nxt   = hit_r;
    ov_nxt    = 1'b0;
    opos_nxt  = opos_r;
    och_nxt   = och_r;
    oco_nxt   = oco_r;
    obot_nxt  = obot_r;
    ram_req   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_opcode);
          ch_nxt    = in_char_code;
          row_nxt   = in_screen_row;
          scol_nxt  = in_screen_col;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        och_nxt   = '0;
        oco_nxt   = '0;
        state_nxt = S_RESP;
        unique case (op_r)
          OP_PRINT: begin
            if (ch_r == CH_NEWLINE) begin
              cpos_nxt  = '0;
              if (ln_r != LINE_MAX) ln_nxt = ln_r + 32'd1;
              lslot_nxt = nslot;
              wslot_nxt = nslot;
              wcol_nxt  = '0;
              fill_nxt  = color_r;
              wresp_nxt = 1'b1;
              state_nxt = S_WALK;
            end else if (ch_r == CH_RETURN) begin
              cpos_nxt = '0;
            end else if (ch_r == CH_BACKSPACE) begin
              if (!(cpos_r == '0 && ln_r == '0)) begin
                if (cpos_r == '0) ln_nxt = ln_r - 32'd1;
                lslot_nxt     = bslot;
                cpos_nxt      = bcol;
                ram_req.we    = 1'b1;
                ram_req.addr  = cell_addr(bslot, bcol);
                ram_req.wdata = {color_r, CH_SPACE};
                state_nxt     = S_SNAP;
              end
            end else begin
              ram_req.we    = 1'b1;
              ram_req.addr  = cell_addr(lslot_r, cpos_r);
              ram_req.wdata = {color_r, ch_r};
              if (cpos_r == CW'(COLUMNS - 1)) begin
                cpos_nxt  = '0;
                if (ln_r != LINE_MAX) ln_nxt = ln_r + 32'd1;
                lslot_nxt = nslot;
                wslot_nxt = nslot;
                wcol_nxt  = '0;
                fill_nxt  = color_r;
                wresp_nxt = 1'b1;
                state_nxt = S_WALK;
              end else begin
                cpos_nxt  = cpos_r + CW'(1);
                state_nxt = S_SNAP;
              end
            end
          end
          OP_LINE_UP: begin
            if (view_r > lo) begin
              view_nxt  = view_r - 32'd1;
              vslot_nxt = slot_sub(vslot_r, (SW+1)'(1));
            end
          end
          OP_LINE_DOWN: begin
            if (view_r < hi) begin
              view_nxt  = view_r + 32'd1;
              vslot_nxt = slot_add(vslot_r, (SW+1)'(1));
            end
          end
          OP_PAGE_UP: begin
            if (view_r - lo > 32'(ROWS - 1)) begin
              view_nxt  = view_r - 32'(ROWS - 1);
              vslot_nxt = slot_sub(vslot_r, (SW+1)'(ROWS - 1));
            end else begin
              view_nxt  = lo;
              vslot_nxt = lo_slot;
            end
          end
          OP_PAGE_DOWN: begin
            if (hi - view_r > 32'(ROWS - 1)) begin
              view_nxt  = view_r + 32'(ROWS - 1);
              vslot_nxt = slot_add(vslot_r, (SW+1)'(ROWS - 1));
            end else begin
              view_nxt  = hi;
              vslot_nxt = hi_slot;
            end
          end
          OP_BOTTOM: begin
            state_nxt = S_SNAP;
          end
          OP_CLEAR: begin
            ln_nxt    = '0;
            lslot_nxt = '0;
            cpos_nxt  = '0;
            view_nxt  = '0;
            vslot_nxt = '0;
            wslot_nxt = '0;
            wcol_nxt  = '0;
            fill_nxt  = color_r;
            wresp_nxt = 1'b1;
            state_nxt = S_WALK;
          end
          OP_READ: begin
            hit_nxt = (row_r < 5'(ROWS)) && (32'(scol_r) < 32'(COLUMNS)) &&
                      (rline >= {1'b0, lo}) && (rline <= {1'b0, ln_r});
            ram_req.re   = 1'b1;
            ram_req.addr = cell_addr(slot_add(vslot_r, (SW+1)'(row_r)), col_t'(scol_r));
            state_nxt    = S_RDWAIT;
          end
          default: ;
        endcase
      end
      S_WALK: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = cell_addr(wslot_r, wcol_r);
        ram_req.wdata = {fill_r, CH_SPACE};
        wcol_nxt      = wcol_r + CW'(1);
        if (wcol_r == CW'(COLUMNS - 1)) state_nxt = wresp_r ? S_SNAP : S_IDLE;
      end
      S_RDWAIT: begin
        if (hit_r) begin
          och_nxt = ram_rdata[7:0];
          oco_nxt = ram_rdata[15:8];
        end else begin
          och_nxt = CH_SPACE;
          oco_nxt = color_r;
        end
        state_nxt = S_RESP;
      end
      S_SNAP: begin
        view_nxt  = hi;
        vslot_nxt = hi_slot;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        opos_nxt  = pos_w[10:0];
        obot_nxt  = (view_r == hi);
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WALK;
      color_r <= COLOR_RESET;
      fill_r  <= COLOR_RESET;
      ln_r    <= '0;
      lslot_r <= '0;
      cpos_r  <= '0;
      view_r  <= '0;
      vslot_r <= '0;
      wslot_r <= '0;
      wcol_r  <= '0;
      wresp_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      color_r <= color_nxt;
      fill_r  <= fill_nxt;
      ln_r    <= ln_nxt;
      lslot_r <= lslot_nxt;
      cpos_r  <= cpos_nxt;
      view_r  <= view_nxt;
      vslot_r <= vslot_nxt;
      wslot_r <= wslot_nxt;
      wcol_r  <= wcol_nxt;
      wresp_r <= wresp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // transaction and result payload
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    row_r  <= row_nxt;
    scol_r <= scol_nxt;
    hit_r  <= hit_nxt;
    opos_r <= opos_nxt;
    och_r  <= och_nxt;
    oco_r  <= oco_nxt;
    obot_r <= obot_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_cursor_pos     = opos_r;
  assign out_cell_char      = och_r;
  assign out_cell_color     = oco_r;
  assign out_view_at_bottom = obot_r;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_view_le_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (view_r <= ln_r)) else $error("view top past current line");
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == S_EXEC || state_r == S_WALK))
    else $error("cell write outside exec or walk");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(cpos_r) < 32'(COLUMNS))) else $error("column out of range");

endmodule
`default_nettype wire
